// ===== design/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU tag lookup.
// No dependencies; every other design file but salru_ram imports this package.
package salru_pkg;

    localparam int NUM_SETS = 64;
    localparam int WAYS     = 8;
    localparam int TAG_BITS = 20;

    localparam int TAG_W  = 20;
    localparam int SET_W  = 6;
    localparam int WAY_W  = 3;
    localparam int CNT_W  = 4;
    localparam int LINE_W = 9;
    localparam int TOT_W  = 32;
    localparam int SET_AW = $clog2(NUM_SETS);

    localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((64'd1 << TAG_BITS) - 64'd1);

    typedef logic [WAY_W-1:0]              t_way;
    typedef logic [WAYS-1:0][WAY_W-1:0]    t_order;
    typedef logic [WAYS-1:0][TAG_W-1:0]    t_tag_row;

    // Per-set recency list (least recent first) and its entry count.
    typedef struct packed {
        t_order           order;
        logic [CNT_W-1:0] fill;
    } t_set_meta;

    localparam int META_W = $bits(t_set_meta);
    localparam int ROW_W  = $bits(t_tag_row);

    typedef struct packed {
        logic      hit;
        t_way      way;
        t_set_meta meta_nx;
    } t_lookup;

endpackage

// ===== design/salru_in_if.sv =====
// Request channel: tag and set index of one access.
// Depends on salru_pkg for field widths.
interface salru_in_if;
    import salru_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] tag;
    logic [SET_W-1:0] set_index;

    modport source (output valid, tag, set_index, input ready);
    modport sink   (input valid, tag, set_index, output ready);
endinterface

// ===== design/salru_out_if.sv =====
// Response channel: hit/miss, way, line index and running totals.
// Depends on salru_pkg for field widths.
interface salru_out_if;
    import salru_pkg::*;

    logic              valid;
    logic              ready;
    logic              is_hit;
    logic [WAY_W-1:0]  way;
    logic [LINE_W-1:0] line_index;
    logic [TOT_W-1:0]  hit_total;
    logic [TOT_W-1:0]  miss_total;

    modport source (output valid, is_hit, way, line_index, hit_total, miss_total,
                    input ready);
    modport sink   (input valid, is_hit, way, line_index, hit_total, miss_total,
                    output ready);
endinterface

// ===== design/salru_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/salru_lookup.sv =====
// Combinational set update: tag compare, victim choice and recency list rework.
// Depends on salru_pkg.
module salru_lookup (
    input  logic [salru_pkg::TAG_W-1:0] i_tag,
    input  logic [salru_pkg::CNT_W-1:0] i_ways,
    input  salru_pkg::t_tag_row         i_row,
    input  salru_pkg::t_set_meta        i_meta,
    output salru_pkg::t_lookup          o_res,
    output salru_pkg::t_tag_row         o_row_nx
);
    import salru_pkg::*;

    always_comb begin
        t_order           ord;
        t_order           sh;
        t_order           nx;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] nm1;
        logic [CNT_W-1:0] fill_nx;
        logic [TAG_W-1:0] tag_m;
        logic             hit;
        logic             srch;
        logic             move;
        t_way             way;
        t_way             pos;

        ord   = i_meta.order;
        n     = i_meta.fill;
        nm1   = n - 1'b1;
        sh    = ord >> WAY_W;
        tag_m = i_tag & TAG_MASK;

        // Ways below the fill count are exactly the valid ones.
        hit = 1'b0;
        way = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (!hit && CNT_W'(k) < i_ways && CNT_W'(k) < n && i_row[k] == tag_m) begin
                hit = 1'b1;
                way = WAY_W'(k);
            end
        end

        srch = 1'b0;
        move = 1'b0;
        pos  = '0;
        if (hit) begin
            for (int k = 0; k < WAYS; k++) begin
                if (!srch && CNT_W'(k) < n && ord[k] == way) begin
                    srch = 1'b1;
                    pos  = WAY_W'(k);
                end
            end
            move = srch;
        end else if (n >= i_ways) begin
            // set full: oldest listed way that is still in use
            for (int k = 0; k < WAYS; k++) begin
                if (!srch && CNT_W'(k) < n && CNT_W'(ord[k]) < i_ways) begin
                    srch = 1'b1;
                    pos  = WAY_W'(k);
                end
            end
            way  = ord[pos];
            move = 1'b1;
        end

        nx      = ord;
        fill_nx = n;
        if (move) begin
            for (int k = 0; k < WAYS; k++) begin
                if (CNT_W'(k) == nm1) begin
                    nx[k] = ord[pos];
                end else if (CNT_W'(k) >= CNT_W'(pos) && CNT_W'(k) < nm1) begin
                    nx[k] = sh[k];
                end
            end
        end
        if (!hit && n < i_ways) begin
            way     = n[WAY_W-1:0];
            nx[way] = way;
            fill_nx = n + 1'b1;
        end

        o_res.hit           = hit;
        o_res.way           = way;
        o_res.meta_nx.order = nx;
        o_res.meta_nx.fill  = fill_nx;

        o_row_nx      = i_row;
        o_row_nx[way] = tag_m;
    end
endmodule

// ===== design/set_assoc_lru_tag_lookup_top.sv =====
// Set-associative LRU tag lookup: top level with FSM, state memories, output register.
// Depends on salru_pkg, salru_in_if, salru_out_if, salru_ram and salru_lookup.
//
// Usage:
//   i_req carries one access (tag, set_index) with valid/ready. o_rsp carries
//   its result (is_hit, way, line_index, hit_total, miss_total) one-for-one.
//   i_cfg_we / i_cfg_wdata write ways_in_use; write it only while idle.
// Sequence:
//   An accepted item reads its set's tag row and recency row from two RAMs
//   (registered read); in S_LOOK the set is updated, the recency row and, on a
//   miss, the tag row are written back and the output register loads. A new
//   item is not taken until this read-then-write of the set rows is through;
//   the result is valid once the output register loads.
//   i_req.ready is high only between items, which keeps a later read behind
//   the earlier write to the same set.
// Stalls:
//   A waiting result does not block the next acceptance; the update of that
//   item holds until the output register frees, then completes.
// Reset:
//   Synchronous, active low. Counters clear, ways_in_use returns to 8 and a
//   per-set flag makes every recency row read as empty; no clearing pass.
module set_assoc_lru_tag_lookup_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [salru_pkg::CNT_W-1:0] i_cfg_wdata,
    salru_in_if.sink                    i_req,
    salru_out_if.source                 o_rsp
);
    import salru_pkg::*;

    localparam int PROD_W = SET_AW + CNT_W + 1;

    typedef enum logic {S_IDLE, S_LOOK} t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_ways;
    logic [NUM_SETS-1:0] r_meta_vld;
    logic                r_row_vld;
    logic [TAG_W-1:0]    r_tag;
    logic [SET_AW-1:0]   r_set;
    logic [TOT_W-1:0]    r_hits;
    logic [TOT_W-1:0]    r_misses;
    logic                r_out_valid;
    logic                r_out_hit;
    t_way                r_out_way;
    logic [LINE_W-1:0]   r_out_line;
    logic [TOT_W-1:0]    r_out_hits;
    logic [TOT_W-1:0]    r_out_misses;

    logic [TOT_W-1:0]    n_hits;
    logic [TOT_W-1:0]    n_misses;

    logic                accept;
    logic                load;
    logic [SET_AW-1:0]   rd_set;
    logic [CNT_W-1:0]    ways_eff;
    logic [ROW_W-1:0]    tag_rdata;
    logic [META_W-1:0]   meta_rdata;
    t_set_meta           meta_cur;
    t_lookup             res;
    t_tag_row            row_nx;
    logic [PROD_W-1:0]   line_full;

    assign accept = i_req.valid && i_req.ready;
    assign load   = (r_state == S_LOOK) && (!r_out_valid || o_rsp.ready);
    assign rd_set = i_req.set_index[SET_AW-1:0];

    assign ways_eff = (r_ways == '0) ? CNT_W'(1) :
                      (r_ways > CNT_W'(WAYS)) ? CNT_W'(WAYS) : r_ways;

    assign meta_cur = r_row_vld ? t_set_meta'(meta_rdata) : '0;

    salru_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (load && !res.hit),
        .i_waddr (r_set),
        .i_wdata (row_nx),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (tag_rdata)
    );

    salru_ram #(.WIDTH(META_W), .DEPTH(NUM_SETS)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (load),
        .i_waddr (r_set),
        .i_wdata (res.meta_nx),
        .i_re    (accept),
        .i_raddr (rd_set),
        .o_rdata (meta_rdata)
    );

    salru_lookup u_lookup (
        .i_tag    (r_tag),
        .i_ways   (ways_eff),
        .i_row    (t_tag_row'(tag_rdata)),
        .i_meta   (meta_cur),
        .o_res    (res),
        .o_row_nx (row_nx)
    );

    assign line_full = PROD_W'(r_set) * PROD_W'(ways_eff) + PROD_W'(res.way);
    assign n_hits    = r_hits + TOT_W'(res.hit);
    assign n_misses  = r_misses + TOT_W'(!res.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ways      <= CNT_W'(WAYS);
            r_meta_vld  <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ways <= i_cfg_wdata;
            end
            // a load in the same cycle refills the output register instead
            if (o_rsp.valid && o_rsp.ready && !load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_tag     <= i_req.tag;
                        r_set     <= rd_set;
                        r_row_vld <= r_meta_vld[rd_set];
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (load) begin
                        r_meta_vld[r_set] <= 1'b1;
                        r_hits            <= n_hits;
                        r_misses          <= n_misses;
                        r_out_valid       <= 1'b1;
                        r_out_hit         <= res.hit;
                        r_out_way         <= res.way;
                        r_out_line        <= line_full[LINE_W-1:0];
                        r_out_hits        <= n_hits;
                        r_out_misses      <= n_misses;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.is_hit     = r_out_hit;
    assign o_rsp.way        = r_out_way;
    assign o_rsp.line_index = r_out_line;
    assign o_rsp.hit_total  = r_out_hits;
    assign o_rsp.miss_total = r_out_misses;
endmodule

// ===== design/salru_chk.sv =====
// Port-level checker for the set-associative LRU tag lookup, bound to the top level.
// Depends on salru_pkg for field widths.
module salru_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_hit,
    input logic [salru_pkg::WAY_W-1:0]  i_out_way,
    input logic [salru_pkg::LINE_W-1:0] i_out_line,
    input logic [salru_pkg::TOT_W-1:0]  i_out_hits,
    input logic [salru_pkg::TOT_W-1:0]  i_out_misses
);
    import salru_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
        && $stable(i_out_way) && $stable(i_out_line)
        && $stable(i_out_hits) && $stable(i_out_misses))
        else $error("result changed while stalled");

    // one item in flight: no acceptance right after one
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("item accepted while previous item still in lookup");

    // a result appearing on an empty output comes from an accepted item, through S_LOOK and the output register
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, 2))
        else $error("result without a matching accepted item");
endmodule

bind set_assoc_lru_tag_lookup_top salru_chk u_salru_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_hit    (o_rsp.is_hit),
    .i_out_way    (o_rsp.way),
    .i_out_line   (o_rsp.line_index),
    .i_out_hits   (o_rsp.hit_total),
    .i_out_misses (o_rsp.miss_total)
);

// ===== dv/set_assoc_lru_tag_lookup_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for set_assoc_lru_tag_lookup_top: an LRU tag store model predicts
// each access; results are compared in order. Depends on salru_pkg and both channel ifs.
module set_assoc_lru_tag_lookup_top_test;
    import salru_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int EXP_DEPTH   = 16;

    typedef struct packed {
        logic              hit;
        t_way              way;
        logic [LINE_W-1:0] line;
        logic [TOT_W-1:0]  hits;
        logic [TOT_W-1:0]  misses;
    } t_lookup_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    salru_in_if  req_if ();
    salru_out_if rsp_if ();

    set_assoc_lru_tag_lookup_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // Model of the tag store and recency lists
    logic [TAG_W-1:0] tag_mem   [NUM_SETS][WAYS];
    logic [WAYS-1:0]  valid_row [NUM_SETS];
    t_way             recency   [NUM_SETS][WAYS];
    int unsigned      fill_cnt  [NUM_SETS];
    logic [TOT_W-1:0] hit_count;
    logic [TOT_W-1:0] miss_count;
    logic [CNT_W-1:0] ways_reg;

    // expected results in acceptance order, ring buffer
    t_lookup_result exp_buf [EXP_DEPTH];
    int unsigned    exp_head;
    int unsigned    exp_tail;
    t_lookup_result rsp_exp;
    int unsigned    accesses_sent;
    int unsigned    results_seen;
    int unsigned    fail_count;
    int unsigned    cycle_count;
    int unsigned    rsp_gap;
    int unsigned    hold_off;
    bit             idle_on;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     exp_tail - exp_head);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Move the entry at position pos of set s to the most recent end.
    function automatic void promote(int unsigned s, int unsigned pos);
        int unsigned n;
        t_way        w;
        n = fill_cnt[s];
        if (n == 0 || pos >= n || n > WAYS)
            return;
        w = recency[s][pos];
        for (int unsigned k = pos; k + 1 < n; k++)
            recency[s][k] = recency[s][k + 1];
        recency[s][n - 1] = w;
    endfunction

    function automatic t_lookup_result predict_lookup(logic [TAG_W-1:0] tag_in,
                                                      logic [SET_W-1:0] set_in);
        int unsigned    s;
        int unsigned    w;
        int unsigned    way;
        int unsigned    pos;
        logic           hit;
        logic           found;
        logic [TAG_W-1:0] tag;
        t_lookup_result r;
        s   = set_in % NUM_SETS;
        tag = tag_in & TAG_MASK;
        w   = ways_reg;
        if (w == 0)
            w = 1;
        if (w > WAYS)
            w = WAYS;
        hit = 1'b0;
        way = 0;
        for (int unsigned k = 0; k < w; k++) begin
            if (!hit && valid_row[s][k] && tag_mem[s][k] == tag) begin
                hit = 1'b1;
                way = k;
            end
        end
        if (hit) begin
            hit_count++;
            pos = WAYS;
            for (int unsigned k = 0; k < fill_cnt[s] && k < WAYS; k++)
                if (pos == WAYS && recency[s][k] == way)
                    pos = k;
            promote(s, pos);
        end else begin
            miss_count++;
            if (fill_cnt[s] < w) begin
                way = fill_cnt[s];
                recency[s][way] = t_way'(way);
                fill_cnt[s]++;
            end else begin
                // oldest listed way that is still in use
                pos   = 0;
                found = 1'b0;
                for (int unsigned k = 0; k < fill_cnt[s] && k < WAYS; k++) begin
                    if (!found && recency[s][k] < w) begin
                        pos   = k;
                        found = 1'b1;
                    end
                end
                way = recency[s][pos];
                promote(s, pos);
            end
            tag_mem[s][way]   = tag;
            valid_row[s][way] = 1'b1;
        end
        r.hit    = hit;
        r.way    = t_way'(way);
        r.line   = LINE_W'(s * w + way);
        r.hits   = hit_count;
        r.misses = miss_count;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [TOT_W-1:0] exp_v,
                               input logic [TOT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result checker; also draws the receiver's stall for the next item
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
            if (exp_tail == exp_head) begin
                fail_count++;
                $display("%0t: unexpected result, expected none actual way %0d", $time,
                         rsp_if.way);
            end else begin
                rsp_exp = exp_buf[exp_head % EXP_DEPTH];
                exp_head++;
                check_field("is_hit", rsp_exp.hit, rsp_if.is_hit);
                check_field("way", rsp_exp.way, rsp_if.way);
                check_field("line_index", rsp_exp.line, rsp_if.line_index);
                check_field("hit_total", rsp_exp.hits, rsp_if.hit_total);
                check_field("miss_total", rsp_exp.misses, rsp_if.miss_total);
            end
            results_seen++;
            rsp_gap = idle_on ? $urandom_range(0, 19) : 0;
        end
    end

    // Receiver ready; a requested hold-off is counted down here
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off != 0) begin
                rsp_if.ready = 1'b0;
                hold_off--;
            end else if (rsp_gap != 0) begin
                rsp_if.ready = 1'b0;
                rsp_gap--;
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    task automatic send_access(input logic [TAG_W-1:0] tag, input logic [SET_W-1:0] set_idx);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.tag       = tag;
        req_if.set_index = set_idx;
        req_if.valid     = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        exp_buf[exp_tail % EXP_DEPTH] = predict_lookup(tag, set_idx);
        exp_tail++;
        accesses_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (exp_tail != exp_head)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_ways(input logic [CNT_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        ways_reg = value;
    endtask

    task automatic apply_reset();
        for (int s = 0; s < NUM_SETS; s++) begin
            valid_row[s] = '0;
            fill_cnt[s]  = 0;
            for (int w = 0; w < WAYS; w++) begin
                tag_mem[s][w] = '0;
                recency[s][w] = '0;
            end
        end
        hit_count  = '0;
        miss_count = '0;
        ways_reg   = CNT_W'(WAYS);
        i_rst_n    = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // Field extremes, fill of a full set and LRU eviction order
    task automatic test_directed();
        send_access('0, '0);
        send_access('0, '0);
        send_access('1, 6'd63);
        send_access('1, 6'd63);
        for (int k = 0; k < WAYS; k++)
            send_access(TAG_W'(20'h10 + k), 6'd1);
        send_access(20'h10, 6'd1);   // way 0 becomes most recent
        send_access(20'h18, 6'd1);   // evicts way 1
        send_access(20'h11, 6'd1);   // evicts way 2
        send_access(20'h12, 6'd1);
        send_access(20'h18, 6'd1);
        send_access(20'hAAAAA, 6'd2);
        send_access(20'h55555, 6'd2);
        drain();
    endtask

    // One way, zero acting as one, values above the way count
    task automatic test_ways_limits();
        set_ways(4'd1);
        send_access(20'hA, 6'd3);
        send_access(20'hA, 6'd3);
        send_access(20'hB, 6'd3);
        send_access(20'hA, 6'd3);
        set_ways(4'd0);
        send_access(20'hC, 6'd4);
        send_access(20'hD, 6'd4);
        send_access(20'hD, 6'd4);
        set_ways(4'd15);
        send_access(20'hE, 6'd5);
        send_access(20'hE, 6'd5);
        set_ways(4'd9);
        send_access(20'hF, 6'd5);
        send_access(20'hE, 6'd5);
        drain();
    endtask

    // Shrink and grow the way count on a partly filled set
    task automatic test_resize();
        set_ways(4'd8);
        for (int k = 0; k < 3; k++)
            send_access(TAG_W'(20'h300 + k), 6'd10);
        set_ways(4'd5);
        for (int k = 3; k < 7; k++)
            send_access(TAG_W'(20'h300 + k), 6'd10);
        set_ways(4'd2);
        send_access(20'h301, 6'd10);
        send_access(20'h303, 6'd10);  // way 3 no longer searched
        send_access(20'h310, 6'd10);
        set_ways(4'd8);
        send_access(20'h311, 6'd10);  // fill resumes at the fill count
        send_access(20'h304, 6'd10);
        send_access(20'h303, 6'd10);
        drain();
    endtask

    task automatic test_random();
        logic [CNT_W-1:0] ways_pick [6];
        logic [TAG_W-1:0] tag_base;
        logic [SET_W-1:0] set_base;
        logic [TAG_W-1:0] tag;
        logic [SET_W-1:0] set_idx;
        ways_pick = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd3};
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 5)
                ways_pick[phase] = CNT_W'($urandom_range(1, 8));
            set_ways(ways_pick[phase]);
            idle_on  = (phase != 2);
            tag_base = TAG_W'($urandom);
            set_base = SET_W'($urandom);
            for (int n = 0; n < 100; n++) begin
                // small tag and set pools keep the sets busy with hits and evictions
                if ($urandom_range(0, 9) == 0)
                    tag = TAG_W'($urandom);
                else
                    tag = tag_base ^ TAG_W'($urandom_range(0, 11));
                if ($urandom_range(0, 6) == 0)
                    set_idx = SET_W'($urandom);
                else
                    set_idx = set_base + SET_W'($urandom_range(0, 3));
                send_access(tag, set_idx);
            end
        end
        idle_on = 1'b1;
        drain();
    endtask

    // Receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_off = 150;
        for (int n = 0; n < 24; n++)
            send_access(TAG_W'(20'h777 + n % 10), SET_W'(20 + n % 3));
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        req_if.valid     = 1'b0;
        req_if.tag       = '0;
        req_if.set_index = '0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        i_rst_n          = 1'b0;
        idle_on          = 1'b1;
        hold_off         = 0;
        rsp_gap          = 0;
        exp_head         = 0;
        exp_tail         = 0;
        accesses_sent    = 0;
        results_seen     = 0;
        fail_count       = 0;
        cycle_count      = 0;
        apply_reset();
        test_directed();
        test_ways_limits();
        test_resize();
        test_random();
        test_backpressure();
        drain();
        $display("Ran %0d accesses, %0d results (%0d hits, %0d misses)", accesses_sent,
                 results_seen, hit_count, miss_count);
        $display("Way counts 0..15 incl. resize, random idling and a long response hold-off");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
